// ----- hw/rtl/rti_pkg.sv -----
`default_nettype none
package rti_pkg;

    // Default coordinate width and the fraction offset (FRAC = COORD_BITS - 4)
    localparam int COORD_BITS = 16;
    localparam int FRAC_OFF   = 4;

    // Port field widths
    localparam int VEC_W  = 48;
    localparam int DIST_W = 24;
    localparam int LANE_W = 16;

    // Distance quotient bits (Q8.16) and integer bits
    localparam int QB     = 24;
    localparam int QB_INT = 8;

    // Normal path: magnitude after scaling, squares, length, lane quotient
    localparam int MAGW = 21;
    localparam int SQW  = 42;
    localparam int LENW = 21;
    localparam int NSQ  = 21;
    localparam int NQB  = 15;
    localparam int NFRAC = 14;

    // Request queue between front and back
    localparam int QDEPTH = 4;

    // Configuration register map
    localparam int             THR_W     = 16;
    localparam logic [0:0]     REG_THR   = 1'b0;
    localparam logic [THR_W-1:0] THR_RESET = 16'd1;

    // Width of the sign-corrected determinant and distance numerator
    function automatic int dw(input int cb);
        return 2 * cb + 10;
    endfunction

    // Width of one queue entry
    function automatic int qent_w(input int cb);
        return 2 + 2 * dw(cb) + LENW + 3 + 3 * MAGW;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/rti_if.sv -----
`default_nettype none
interface rti_req_if;
    import rti_pkg::*;
    logic             valid;
    logic             ready;
    logic [VEC_W-1:0] ray_origin;
    logic [VEC_W-1:0] ray_direction;
    logic [VEC_W-1:0] vertex_zero;
    logic [VEC_W-1:0] vertex_one;
    logic [VEC_W-1:0] vertex_two;

    modport source (output valid, ray_origin, ray_direction, vertex_zero, vertex_one,
                    vertex_two, input ready);
    modport sink   (input valid, ray_origin, ray_direction, vertex_zero, vertex_one,
                    vertex_two, output ready);
endinterface

interface rti_rsp_if;
    import rti_pkg::*;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [DIST_W-1:0] hit_distance;
    logic [VEC_W-1:0]  surface_normal;

    modport source (output valid, hit, hit_distance, surface_normal, input ready);
    modport sink   (input valid, hit, hit_distance, surface_normal, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/rti_front.sv -----
`default_nettype none
module rti_front #(
    parameter int CB = rti_pkg::COORD_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    rti_req_if.sink                            i_req,
    input  wire logic [rti_pkg::THR_W-1:0]     i_thr,
    input  wire logic                          i_full,
    output logic                               o_push,
    output logic [rti_pkg::qent_w(CB)-1:0]     o_ent
);
    import rti_pkg::*;

    localparam int FRAC = CB - FRAC_OFF;
    localparam int EW   = CB + 1;
    localparam int PXW  = 2 * CB + 2;
    localparam int NXW  = 2 * CB + 3;
    localparam int HQW  = CB + 7;
    localparam int PW   = 2 * CB + 8;
    localparam int SW   = 2 * CB + 11;
    localparam int DW   = dw(CB);
    localparam int SHW  = $clog2(NXW);
    localparam int NX1[3] = '{1, 2, 0};
    localparam int NX2[3] = '{2, 0, 1};

    typedef struct packed {
        logic                 ok;
        logic                 sat;
        logic [DW-1:0]        d;
        logic [DW-1:0]        t;
        logic [2:0]           sgn;
        logic [2:0][MAGW-1:0] mag;
    } t_car;

    typedef struct packed {
        logic                 ok;
        logic                 sat;
        logic [DW-1:0]        d;
        logic [DW-1:0]        t;
        logic [LENW-1:0]      len;
        logic [2:0]           sgn;
        logic [2:0][MAGW-1:0] mag;
    } t_ent;

    logic       en;
    logic [7:0] r_v;
    logic [NSQ:0] r_iv;

    // Advance the whole front unless the last stage holds a request the queue cannot take
    assign en          = !r_iv[NSQ] || !i_full;
    assign i_req.ready = en;
    assign o_push      = r_iv[NSQ] && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_iv <= '0;
        end else if (en) begin
            r_v  <= {r_v[6:0], i_req.valid};
            r_iv <= {r_iv[NSQ-1:0], r_v[7]};
        end
    end

    // Stage 1: unpack and form edges and origin offset
    logic [3*CB-1:0] w_o, w_d, w_v0, w_v1, w_v2;
    assign w_o  = (3*CB)'(i_req.ray_origin);
    assign w_d  = (3*CB)'(i_req.ray_direction);
    assign w_v0 = (3*CB)'(i_req.vertex_zero);
    assign w_v1 = (3*CB)'(i_req.vertex_one);
    assign w_v2 = (3*CB)'(i_req.vertex_two);

    logic signed [EW-1:0] r1_e1 [3], r1_e2 [3], r1_s [3];
    logic signed [CB-1:0] r1_d  [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r1_e1[k] <= EW'($signed(w_v1[k*CB +: CB])) - EW'($signed(w_v0[k*CB +: CB]));
                r1_e2[k] <= EW'($signed(w_v2[k*CB +: CB])) - EW'($signed(w_v0[k*CB +: CB]));
                r1_s[k]  <= EW'($signed(w_o[k*CB +: CB]))  - EW'($signed(w_v0[k*CB +: CB]));
                r1_d[k]  <= $signed(w_d[k*CB +: CB]);
            end
        end
    end

    // Stage 2: cross product terms for h = d x e2, q = s x e1, n = e1 x e2
    logic signed [PXW-1:0] r2_hp [3][2], r2_qp [3][2], r2_np [3][2];
    logic signed [EW-1:0]  r2_e1 [3], r2_e2 [3], r2_s [3];
    logic signed [CB-1:0]  r2_d  [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r2_hp[k][0] <= PXW'(r1_d[NX1[k]]) * PXW'(r1_e2[NX2[k]]);
                r2_hp[k][1] <= PXW'(r1_d[NX2[k]]) * PXW'(r1_e2[NX1[k]]);
                r2_qp[k][0] <= PXW'(r1_s[NX1[k]]) * PXW'(r1_e1[NX2[k]]);
                r2_qp[k][1] <= PXW'(r1_s[NX2[k]]) * PXW'(r1_e1[NX1[k]]);
                r2_np[k][0] <= PXW'(r1_e1[NX1[k]]) * PXW'(r1_e2[NX2[k]]);
                r2_np[k][1] <= PXW'(r1_e1[NX2[k]]) * PXW'(r1_e2[NX1[k]]);
                r2_e1[k]    <= r1_e1[k];
                r2_e2[k]    <= r1_e2[k];
                r2_s[k]     <= r1_s[k];
                r2_d[k]     <= r1_d[k];
            end
        end
    end

    // Stage 3: finish cross products, floor shift h and q
    logic signed [HQW-1:0] r3_h [3], r3_q [3];
    logic signed [NXW-1:0] r3_n [3];
    logic signed [EW-1:0]  r3_e1 [3], r3_e2 [3], r3_s [3];
    logic signed [CB-1:0]  r3_d  [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r3_h[k]  <= HQW'((NXW'(r2_hp[k][0]) - NXW'(r2_hp[k][1])) >>> FRAC);
                r3_q[k]  <= HQW'((NXW'(r2_qp[k][0]) - NXW'(r2_qp[k][1])) >>> FRAC);
                r3_n[k]  <= NXW'(r2_np[k][0]) - NXW'(r2_np[k][1]);
                r3_e1[k] <= r2_e1[k];
                r3_e2[k] <= r2_e2[k];
                r3_s[k]  <= r2_s[k];
                r3_d[k]  <= r2_d[k];
            end
        end
    end

    // Stage 4: dot product terms, normal magnitudes
    logic signed [PW-1:0]  r4_pd [3], r4_pu [3], r4_pv [3], r4_pt [3];
    logic signed [NXW-1:0] r4_n  [3];
    logic        [NXW-1:0] r4_na [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r4_pd[k] <= PW'(r3_e1[k]) * PW'(r3_h[k]);
                r4_pu[k] <= PW'(r3_s[k])  * PW'(r3_h[k]);
                r4_pv[k] <= PW'(r3_d[k])  * PW'(r3_q[k]);
                r4_pt[k] <= PW'(r3_e2[k]) * PW'(r3_q[k]);
                r4_n[k]  <= r3_n[k];
                r4_na[k] <= r3_n[k][NXW-1] ? NXW'(-r3_n[k]) : NXW'(r3_n[k]);
            end
        end
    end

    // Stage 5: sum dot products, merge magnitudes for the leading one
    logic signed [SW-1:0]  r5_det, r5_un, r5_vn, r5_tn;
    logic signed [NXW-1:0] r5_n [3];
    logic        [NXW-1:0] r5_or;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_det <= SW'(r4_pd[0]) + SW'(r4_pd[1]) + SW'(r4_pd[2]);
            r5_un  <= SW'(r4_pu[0]) + SW'(r4_pu[1]) + SW'(r4_pu[2]);
            r5_vn  <= SW'(r4_pv[0]) + SW'(r4_pv[1]) + SW'(r4_pv[2]);
            r5_tn  <= SW'(r4_pt[0]) + SW'(r4_pt[1]) + SW'(r4_pt[2]);
            r5_or  <= r4_na[0] | r4_na[1] | r4_na[2];
            for (int k = 0; k < 3; k++) begin
                r5_n[k] <= r4_n[k];
            end
        end
    end

    // Stage 6: fold the determinant sign, test for parallel, pick the normal shift
    logic              n6_neg;
    logic [SHW-1:0]    n6_sh;
    logic signed [SW-1:0] n6_det;

    always_comb begin
        n6_neg = r5_det[SW-1];
        n6_det = n6_neg ? -r5_det : r5_det;
        n6_sh  = '0;
        for (int i = 20; i < NXW; i++) begin
            if (r5_or[i]) begin
                n6_sh = SHW'(i - 19);
            end
        end
    end

    logic signed [SW-1:0]  r6_det, r6_un, r6_vn, r6_tn;
    logic                  r6_par;
    logic [SHW-1:0]        r6_sh;
    logic signed [NXW-1:0] r6_n [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_det <= n6_det;
            r6_un  <= n6_neg ? -r5_un : r5_un;
            r6_vn  <= n6_neg ? -r5_vn : r5_vn;
            r6_tn  <= n6_neg ? -r5_tn : r5_tn;
            r6_par <= $unsigned(n6_det) < SW'(i_thr);
            r6_sh  <= n6_sh;
            for (int k = 0; k < 3; k++) begin
                r6_n[k] <= r5_n[k];
            end
        end
    end

    // Stage 7: classify hit candidates, scale the normal
    t_car n7_car;

    always_comb begin
        logic signed [SW:0]     uv;
        logic signed [NXW-1:0]  sv;
        logic signed [MAGW-1:0] mv;
        uv = (SW+1)'(r6_un) + (SW+1)'(r6_vn);
        n7_car.ok = !r6_par && (r6_det != '0)
                 && !r6_un[SW-1] && (r6_un <= r6_det)
                 && !r6_vn[SW-1] && (uv <= (SW+1)'(r6_det))
                 && (r6_tn > 0);
        n7_car.d   = DW'(r6_det);
        n7_car.t   = DW'(r6_tn);
        n7_car.sat = {8'd0, DW'(r6_tn)} >= {DW'(r6_det), 8'd0};
        for (int k = 0; k < 3; k++) begin
            sv = r6_n[k] >>> r6_sh;
            mv = MAGW'(sv);
            n7_car.sgn[k] = mv[MAGW-1];
            n7_car.mag[k] = mv[MAGW-1] ? MAGW'(-mv) : MAGW'(mv);
        end
    end

    t_car r7_car, r8_car;
    logic [SQW-1:0] r8_sq [3];

    // Stage 8: square the scaled components
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_car <= n7_car;
            r8_car <= r7_car;
            for (int k = 0; k < 3; k++) begin
                r8_sq[k] <= SQW'(r7_car.mag[k]) * SQW'(r7_car.mag[k]);
            end
        end
    end

    // Integer square root, one result bit per stage
    logic [SQW-1:0] r_ix [NSQ+1];
    logic [SQW-1:0] r_ir [NSQ+1];
    t_car           r_ic [NSQ+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ix[0] <= r8_sq[0] + r8_sq[1] + r8_sq[2];
            r_ir[0] <= '0;
            r_ic[0] <= r8_car;
        end
    end

    for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
        localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * j);
        logic [SQW-1:0] trial;
        assign trial = r_ir[j] + BIT;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_ix[j] >= trial) begin
                    r_ix[j+1] <= r_ix[j] - trial;
                    r_ir[j+1] <= (r_ir[j] >> 1) + BIT;
                end else begin
                    r_ix[j+1] <= r_ix[j];
                    r_ir[j+1] <= r_ir[j] >> 1;
                end
                r_ic[j+1] <= r_ic[j];
            end
        end
    end

    // Pack the finished request for the queue
    t_ent w_ent;
    always_comb begin
        w_ent.ok  = r_ic[NSQ].ok;
        w_ent.sat = r_ic[NSQ].sat;
        w_ent.d   = r_ic[NSQ].d;
        w_ent.t   = r_ic[NSQ].t;
        w_ent.len = r_ir[NSQ][LENW-1:0];
        w_ent.sgn = r_ic[NSQ].sgn;
        w_ent.mag = r_ic[NSQ].mag;
    end
    assign o_ent = w_ent;

endmodule
`default_nettype wire

// ----- hw/rtl/rti_queue.sv -----
`default_nettype none
module rti_queue #(
    parameter int W     = 8,
    parameter int DEPTH = rti_pkg::QDEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);
    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [W-1:0]    r_mem [DEPTH];
    logic [PTRW-1:0] r_wp, r_rp;
    logic [CNTW-1:0] r_cnt;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTRW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTRW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/rti_back.sv -----
`default_nettype none
module rti_back #(
    parameter int CB = rti_pkg::COORD_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_empty,
    input  wire logic [rti_pkg::qent_w(CB)-1:0] i_ent,
    output logic                               o_pop,
    rti_rsp_if.source                          o_rsp
);
    import rti_pkg::*;

    localparam int DW   = dw(CB);
    localparam int NUMW = MAGW + NFRAC;

    typedef struct packed {
        logic                 ok;
        logic                 sat;
        logic [DW-1:0]        d;
        logic [DW-1:0]        t;
        logic [LENW-1:0]      len;
        logic [2:0]           sgn;
        logic [2:0][MAGW-1:0] mag;
    } t_ent;

    typedef struct packed {
        logic                 ok;
        logic                 sat;
        logic [DW-1:0]        d;
        logic [QB_INT-1:0]    tlo;
        logic [DW-1:0]        rem;
        logic [QB-1:0]        tq;
        logic [LENW-1:0]      len;
        logic [2:0]           sgn;
        logic [2:0][NQB-1:0]  nlo;
        logic [2:0][LENW-1:0] nrem;
        logic [2:0][NQB-1:0]  nq;
    } t_bst;

    logic en;
    logic [QB:0] r_bv;
    t_bst r_bs [QB+1];
    logic r_ov;

    // Advance unless the output register holds an untaken result
    assign en    = !r_ov || o_rsp.ready;
    assign o_pop = en && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_bv <= {r_bv[QB-1:0], o_pop};
            r_ov <= r_bv[QB];
        end
    end

    // Set up both dividers from the popped request
    t_ent w_e;
    t_bst w_init;
    assign w_e = i_ent;

    always_comb begin
        logic [NUMW-1:0] num;
        w_init.ok  = w_e.ok;
        w_init.sat = w_e.sat;
        w_init.d   = w_e.d;
        w_init.tlo = w_e.t[QB_INT-1:0];
        w_init.rem = w_e.t >> QB_INT;
        w_init.tq  = '0;
        w_init.len = w_e.len;
        w_init.sgn = w_e.sgn;
        w_init.nq  = '0;
        for (int k = 0; k < 3; k++) begin
            num = {w_e.mag[k], NFRAC'(0)} + NUMW'(w_e.len >> 1);
            w_init.nlo[k]  = num[NQB-1:0];
            w_init.nrem[k] = LENW'(num >> NQB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bs[0] <= w_init;
        end
    end

    // Long division: distance on every stage, normal lanes on the first stages
    for (genvar s = 0; s < QB; s++) begin : g_div
        t_bst n_bs;
        always_comb begin
            logic [DW:0]   trial;
            logic [LENW:0] ntrial;
            logic          bin;
            n_bs = r_bs[s];
            bin  = (s < QB_INT) ? r_bs[s].tlo[QB_INT-1-((s < QB_INT) ? s : 0)] : 1'b0;
            trial = {r_bs[s].rem, bin};
            if (trial >= {1'b0, r_bs[s].d}) begin
                n_bs.rem = DW'(trial - {1'b0, r_bs[s].d});
                n_bs.tq[QB-1-s] = 1'b1;
            end else begin
                n_bs.rem = DW'(trial);
            end
            if (s < NQB) begin
                for (int k = 0; k < 3; k++) begin
                    ntrial = {r_bs[s].nrem[k], r_bs[s].nlo[k][NQB-1-((s < NQB) ? s : 0)]};
                    if (ntrial >= {1'b0, r_bs[s].len}) begin
                        n_bs.nrem[k] = LENW'(ntrial - {1'b0, r_bs[s].len});
                        n_bs.nq[k][NQB-1-((s < NQB) ? s : 0)] = 1'b1;
                    end else begin
                        n_bs.nrem[k] = LENW'(ntrial);
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_bs[s+1] <= n_bs;
            end
        end
    end

    // Compose the result: saturate, drop zero distance, sign the normal
    logic              r_hit;
    logic [DIST_W-1:0] r_dist;
    logic [VEC_W-1:0]  r_norm;

    always_ff @(posedge i_clk) begin
        logic [QB-1:0]     t;
        logic              h;
        logic [LANE_W-1:0] lane;
        if (en) begin
            t = r_bs[QB].sat ? '1 : r_bs[QB].tq;
            h = r_bs[QB].ok && (t != '0);
            r_hit  <= h;
            r_dist <= h ? DIST_W'(t) : '0;
            for (int k = 0; k < 3; k++) begin
                lane = LANE_W'(r_bs[QB].nq[k]);
                if (r_bs[QB].sgn[k]) begin
                    lane = -lane;
                end
                r_norm[k*LANE_W +: LANE_W] <= (h && (r_bs[QB].len != '0)) ? lane : '0;
            end
        end
    end

    assign o_rsp.valid          = r_ov;
    assign o_rsp.hit            = r_hit;
    assign o_rsp.hit_distance   = r_dist;
    assign o_rsp.surface_normal = r_norm;

endmodule
`default_nettype wire

// ----- hw/rtl/ray_triangle_intersect.sv -----
// Ray/triangle intersection, one request per cycle sustained while results are taken.
// Built from a 30-stage front with a 21-step square root, a 4-entry queue and a 24-step divider.
// The front stalls only when the queue is full; the back only on output stall.
// Reset (synchronous, active low) empties the pipeline and queue and sets
// the parallel threshold to 1.
`default_nettype none
module ray_triangle_intersect #(
    parameter int COORD_BITS = rti_pkg::COORD_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    rti_req_if.sink                         i_req,
    rti_rsp_if.source                       o_rsp,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import rti_pkg::*;

    localparam int QEW = qent_w(COORD_BITS);

    logic [THR_W-1:0] r_thr;

    // Write the threshold register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_THR)) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THR) ? 32'(r_thr) : '0;

    logic           push, full, pop, empty;
    logic [QEW-1:0] ent_in, ent_out;

    rti_front #(.CB(COORD_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_thr   (r_thr),
        .i_full  (full),
        .o_push  (push),
        .o_ent   (ent_in)
    );

    rti_queue #(.W(QEW), .DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (ent_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (ent_out),
        .o_empty (empty)
    );

    rti_back #(.CB(COORD_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_ent   (ent_out),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule
`default_nettype wire
